// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the matrix multiply engine RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// File: hw/rtl/mme_pkg.sv
// Package for the matrix multiply engine: command codes, register indexes,
// field widths and the controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package mme_pkg;

	// Input command codes
	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROWS_A    = 2'd0;
	localparam logic [1:0] CFG_INNER_LEN = 2'd1;
	localparam logic [1:0] CFG_COLS_B    = 2'd2;

	// Fixed field widths
	localparam int CMD_W      = 2;
	localparam int IDX_W      = 3;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int VALUE_W    = 35;
	localparam int OUT_DATA_W = 48;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic             wr_a;       // store the incoming element into A
		logic             wr_b;       // store the incoming element into B
		logic             issue;      // read one A/B pair and multiply it
		logic             first_k;    // first term of a dot product
		logic             last_k;     // final term of a dot product
		logic             last_elem;  // final element of the product
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic res_wr;    // a finished dot product enters the output register
		logic out_full;  // the output register holds an untaken result
	} dp_sts_t;

endpackage

// File: hw/rtl/mme_ctrl.sv
// Controller of the matrix multiply engine: configuration registers, input
// acceptance and the row/column/inner-index sequencer. Uses mme_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mme_ctrl #(
	parameter int MAX_DIM = 8,
	parameter int DW      = 3,
	parameter int AW      = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [mme_pkg::CMD_W-1:0]    in_cmd,
	input  logic [mme_pkg::IDX_W-1:0]    in_row,
	input  logic [mme_pkg::IDX_W-1:0]    in_col,
	output mme_pkg::dp_cmd_t             cmd,
	output logic [AW-1:0]                rd_addr_a,
	output logic [AW-1:0]                rd_addr_b,
	input  mme_pkg::dp_sts_t             sts
);
	import mme_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WAIT  = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] rows_a_q, inner_len_q, cols_b_q;
	logic [DW-1:0]    n_m1_q, m_m1_q, kc_m1_q;
	logic [DW-1:0]    r_q, c_q, k_q;
	logic             accept, in_range, last_elem;

	// A register value of zero acts as one; a value above MAX_DIM acts as MAX_DIM.
	function automatic logic [DW-1:0] clamp_m1(input logic [CFG_W-1:0] v);
		logic [DW-1:0] res;
		if (v == '0)
			res = '0;
		else if (32'(v) > MAX_DIM)
			res = DW'(MAX_DIM - 1);
		else
			res = DW'(v - 1'b1);
		return res;
	endfunction

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_range  = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
	assign last_elem = (r_q == n_m1_q) && (c_q == kc_m1_q);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= CFG_W'(8);
			inner_len_q <= CFG_W'(8);
			cols_b_q    <= CFG_W'(8);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ROWS_A:    rows_a_q    <= cfg_data;
				CFG_INNER_LEN: inner_len_q <= cfg_data;
				CFG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: row, column and inner index of the current dot product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			n_m1_q  <= '0;
			m_m1_q  <= '0;
			kc_m1_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_cmd == CMD_COMPUTE) begin
						n_m1_q  <= clamp_m1(rows_a_q);
						m_m1_q  <= clamp_m1(inner_len_q);
						kc_m1_q <= clamp_m1(cols_b_q);
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// Start an element only once the output register is free.
					if (!sts.out_full)
						state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					if (k_q == m_m1_q) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (sts.res_wr) begin
						if (last_elem) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_WAIT;
							if (c_q == kc_m1_q) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Commands and read addresses for the datapath.
	always_comb begin
		cmd.wr_a      = accept && (in_cmd == CMD_LOAD_A) && in_range;
		cmd.wr_b      = accept && (in_cmd == CMD_LOAD_B) && in_range;
		cmd.issue     = (state_q == ST_ISSUE);
		cmd.first_k   = (k_q == '0);
		cmd.last_k    = (k_q == m_m1_q);
		cmd.last_elem = last_elem;
		cmd.row       = IDX_W'(r_q);
		cmd.col       = IDX_W'(c_q);
	end

	assign rd_addr_a = AW'(r_q) * AW'(MAX_DIM) + AW'(k_q);
	assign rd_addr_b = AW'(k_q) * AW'(MAX_DIM) + AW'(c_q);

	// The output register stays empty while a dot product is being issued.
	`ASSERT_NEVER(a_issue_out_empty, clk, arst_n, (state_q == ST_ISSUE) && sts.out_full, "output register full during issue")
	// The final element of a product returns the controller to idle.
	`ASSERT_AT(a_last_to_idle, clk, arst_n, (state_q == ST_DRAIN) && sts.res_wr && last_elem |=> (state_q == ST_IDLE), "no return to idle after final element")

endmodule

// File: hw/rtl/mme_datapath.sv
// Datapath of the matrix multiply engine: the A and B element stores, the
// multiply-accumulate pipeline and the output register. Uses mme_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mme_datapath #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16,
	parameter int AW         = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mme_pkg::dp_cmd_t                  cmd,
	input  logic [AW-1:0]                     rd_addr_a,
	input  logic [AW-1:0]                     rd_addr_b,
	input  logic [mme_pkg::IDX_W-1:0]         in_row,
	input  logic [mme_pkg::IDX_W-1:0]         in_col,
	input  logic [ELEM_WIDTH-1:0]             in_elem,
	output mme_pkg::dp_sts_t                  sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mme_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);
	import mme_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

	logic [AW-1:0]                  wr_addr;
	logic signed [ELEM_WIDTH-1:0]   a_s1, b_s1;
	logic                           valid_s1, first_s1, lastk_s1, lastel_s1;
	logic [IDX_W-1:0]               row_s1, col_s1;
	logic signed [2*ELEM_WIDTH-1:0] prod_full;
	logic signed [VALUE_W-1:0]      prod_s2;
	logic                           valid_s2, first_s2, lastk_s2, lastel_s2;
	logic [IDX_W-1:0]               row_s2, col_s2;
	logic [VALUE_W-1:0]             acc_q, sum;
	logic                           out_valid_q, out_last_q;
	logic [IDX_W-1:0]               out_row_q, out_col_q;
	logic [VALUE_W-1:0]             out_value_q;

	assign wr_addr = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);

	// Element stores: one write port for loads, registered read for the sequencer.
	always_ff @(posedge clk) begin
		if (cmd.wr_a)
			mem_a[wr_addr] <= in_elem;
		a_s1 <= mem_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b)
			mem_b[wr_addr] <= in_elem;
		b_s1 <= mem_b[rd_addr_b];
	end

	// Stage 1 tags travel alongside the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= cmd.issue;
	end

	always_ff @(posedge clk) begin
		first_s1  <= cmd.first_k;
		lastk_s1  <= cmd.last_k;
		lastel_s1 <= cmd.last_elem;
		row_s1    <= cmd.row;
		col_s1    <= cmd.col;
	end

	// Stage 2: signed product, kept modulo 2^VALUE_W.
	assign prod_full = a_s1 * b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		prod_s2   <= VALUE_W'(prod_full);
		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;
	end

	// Accumulator: each dot product starts from zero on its first term.
	assign sum = (first_s2 ? '0 : acc_q) + VALUE_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (valid_s2)
			acc_q <= sum;
	end

	// Output register: loaded with a finished dot product, cleared on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (sts.res_wr)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (sts.res_wr) begin
			out_value_q <= sum;
			out_row_q   <= row_s2;
			out_col_q   <= col_s2;
			out_last_q  <= lastel_s2;
		end
	end

	assign sts.res_wr   = valid_s2 && lastk_s2;
	assign sts.out_full = out_valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_W - VALUE_W - 2 * IDX_W){1'b0}},
		out_value_q, out_col_q, out_row_q};

	// A finished dot product never overwrites an untaken result.
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, sts.res_wr && out_valid_q, "result written into a full output register")
	// The output register only fills from a finished dot product.
	`ASSERT_AT(a_fill_source, clk, arst_n, $rose(out_valid_q) |-> $past(sts.res_wr), "output register filled without a result")

endmodule

// File: hw/rtl/matrix_multiply_engine_core.sv
// Channel   Direction  Contents
// s_axis    in         load A/B element or compute command
// m_axis    out        one product element per transfer, tlast on the final one
// cfg       in         write-only dimension registers rows_a, inner_len, cols_b
//
// An in-range load writes one element into the A or B store. A compute emits
// rows_a x cols_b elements one at a time, all from the single shared
// multiply-accumulate unit fed by one read port on each element store.
// The input is not ready from a compute transfer until its final result is in the
// output register. A stalled sink holds the sequencer before the next element.
// Reset clears control state only; the element stores hold no defined value.
//
// Top level of the matrix multiply engine. Depends on mme_pkg, mme_ctrl
// and mme_datapath.
`timescale 1ns / 1ps

module matrix_multiply_engine_core #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// command[1:0], row_index[4:2], col_index[7:5], elem_value[8 +: ELEM_WIDTH]
	input  logic [((8 + ELEM_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_row[2:0], out_col[5:3], out_value[40:6], zeros above
	output logic [mme_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                 m_tlast
);
	import mme_pkg::*;

	localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

	logic [CMD_W-1:0]      in_cmd;
	logic [IDX_W-1:0]      in_row, in_col;
	logic [ELEM_WIDTH-1:0] in_elem;
	dp_cmd_t               cmd;
	dp_sts_t               sts;
	logic [AW-1:0]         rd_addr_a, rd_addr_b;

	// Unpack the input transfer.
	assign in_cmd  = s_tdata[CMD_W-1:0];
	assign in_row  = s_tdata[CMD_W +: IDX_W];
	assign in_col  = s_tdata[CMD_W + IDX_W +: IDX_W];
	assign in_elem = s_tdata[CMD_W + 2 * IDX_W +: ELEM_WIDTH];

	mme_ctrl #(
		.MAX_DIM (MAX_DIM),
		.DW      (DW),
		.AW      (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.in_cmd    (in_cmd),
		.in_row    (in_row),
		.in_col    (in_col),
		.cmd       (cmd),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.sts       (sts)
	);

	mme_datapath #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH),
		.AW         (AW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.in_row    (in_row),
		.in_col    (in_col),
		.in_elem   (in_elem),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
